/* rtl/core/ttps_pkg.sv */
// Shared types, constants and helper functions for the tunnel texture pixel shader.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package ttps_pkg;

   localparam int COORD_W      = 8;
   localparam int SIZE_W       = 9;
   localparam int COLOR_W      = 8;
   localparam int STEP_W       = 16;
   localparam int POS_W        = 17;
   localparam int FRAC_W       = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 8;
   localparam int DIV_BITS     = COORD_W;
   localparam int DIV_PER_STG  = 2;
   localparam int DIV_STAGES   = DIV_BITS / DIV_PER_STG;

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(32'h1_0000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHADE_EN  = 3'd0,
      CSR_BLOCK_W   = 3'd1,
      CSR_BLOCK_H   = 3'd2,
      CSR_EVEN      = 3'd3,
      CSR_ODD       = 3'd4,
      CSR_MOVE_STEP = 3'd5,
      CSR_TURN_STEP = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                     shade_en;
      logic [SIZE_W-1:0]        block_w;
      logic [SIZE_W-1:0]        block_h;
      logic [COLOR_W-1:0]       even_color;
      logic [COLOR_W-1:0]       odd_color;
      logic signed [STEP_W-1:0] move_step;
      logic signed [STEP_W-1:0] turn_step;
   } cfg_type;

   // One pixel after address forming: texture row and column, shade level and frame end.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] shade;
      logic               fend;
   } pix_type;

   // One pixel inside the block-count divider.
   typedef struct packed {
      logic [COORD_W-1:0] rem_row;
      logic [COORD_W-1:0] rem_col;
      logic [COORD_W-1:0] shade;
      logic               fend;
      logic               par;
   } div_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [COORD_W:0] div_step(input logic [COORD_W-1:0] rem,
                                                 input logic [SIZE_W-1:0]  dv,
                                                 input logic [2:0]         sh);
      logic [2*COORD_W-1:0] sub;
      logic [COORD_W:0]     res;
      sub = {{(2*COORD_W-SIZE_W){1'b0}}, dv} << sh;
      if ({{COORD_W{1'b0}}, rem} >= sub) begin
         res = {1'b1, rem - sub[COORD_W-1:0]};
      end else begin
         res = {1'b0, rem};
      end
      return res;
   endfunction

   // Position advance with wrap: above the top goes to zero, below zero goes to the top.
   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0]        pos,
                                                input logic signed [STEP_W-1:0] step);
      logic signed [POS_W+1:0] p;
      logic [POS_W-1:0]        res;
      p = $signed({2'b00, pos}) + (POS_W+2)'(step);
      if (p > $signed({2'b00, POS_MAX})) begin
         res = '0;
      end else if (p < 0) begin
         res = POS_MAX;
      end else begin
         res = p[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/core/ttps_addr.sv */
// Input stage: forms the texel row and column from the map entry and the frame positions.
// Holds the movement and rotation positions. Uses ttps_pkg.
module ttps_addr (
   input  logic               clock,
   input  logic               reset,
   input  ttps_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         angle_coord,
   input  logic [7:0]         depth_coord,
   input  logic [7:0]         shade_level,
   input  logic               frame_end,
   output logic               out_valid,
   input  logic               out_ready,
   output ttps_pkg::pix_type  out_data
);

   logic                        valid_ff;
   ttps_pkg::pix_type           data_ff;
   ttps_pkg::pix_type           data_in;
   logic [ttps_pkg::POS_W-1:0]  move_pos_ff;
   logic [ttps_pkg::POS_W-1:0]  turn_pos_ff;
   logic [ttps_pkg::POS_W-1:0]  move_pos_in;
   logic [ttps_pkg::POS_W-1:0]  turn_pos_in;
   logic [ttps_pkg::COORD_W-1:0] row_pre;
   logic [2*ttps_pkg::COORD_W-1:0] addr;
   logic                        accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // An integer position of 256 leaves the row unchanged after the byte mask.
      row_pre = depth_coord + move_pos_ff[ttps_pkg::FRAC_W +: ttps_pkg::COORD_W];
      addr    = {row_pre, angle_coord}
              - {7'b0, turn_pos_ff[ttps_pkg::POS_W-1:ttps_pkg::FRAC_W]};
      data_in.row   = addr[15:8];
      data_in.col   = addr[7:0];
      data_in.shade = shade_level;
      data_in.fend  = frame_end;
      move_pos_in = move_pos_ff;
      turn_pos_in = turn_pos_ff;
      if (accept && frame_end) begin
         move_pos_in = ttps_pkg::advance(move_pos_ff, cfg.move_step);
         turn_pos_in = ttps_pkg::advance(turn_pos_ff, cfg.turn_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         move_pos_ff <= '0;
         turn_pos_ff <= '0;
      end else begin
         move_pos_ff <= move_pos_in;
         turn_pos_ff <= turn_pos_in;
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      move_pos_ff <= ttps_pkg::POS_MAX && turn_pos_ff <= ttps_pkg::POS_MAX)
      else $error("frame position out of range");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && frame_end) |=> $stable(move_pos_ff) && $stable(turn_pos_ff))
      else $error("frame position moved without a frame end");

endmodule

/* rtl/core/ttps_div.sv */
// Pipelined restoring divider that finds the checkerboard parity of a texel.
// Two quotient bits per stage for row and column in parallel. Uses ttps_pkg.
module ttps_div (
   input  logic               clock,
   input  logic               reset,
   input  ttps_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ttps_pkg::pix_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ttps_pkg::div_type  out_data
);

   localparam int NS = ttps_pkg::DIV_STAGES;

   logic                        valid_ff [NS];
   ttps_pkg::div_type           data_ff  [NS];
   ttps_pkg::div_type           src      [NS];
   ttps_pkg::div_type           nxt      [NS];
   logic                        src_valid [NS];
   logic                        rdy      [NS+1];
   logic [ttps_pkg::SIZE_W-1:0] bw_eff;
   logic [ttps_pkg::SIZE_W-1:0] bh_eff;

   // A block size of zero behaves as one.
   assign bw_eff = (cfg.block_w == '0) ? ttps_pkg::SIZE_W'(1) : cfg.block_w;
   assign bh_eff = (cfg.block_h == '0) ? ttps_pkg::SIZE_W'(1) : cfg.block_h;

   assign rdy[NS]   = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[NS-1];
   assign out_data  = data_ff[NS-1];

   always_comb begin
      src[0].rem_row = in_data.row;
      src[0].rem_col = in_data.col;
      src[0].shade   = in_data.shade;
      src[0].fend    = in_data.fend;
      src[0].par     = 1'b0;
      src_valid[0]   = in_valid;
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int TOP = ttps_pkg::DIV_BITS - 1 - s * ttps_pkg::DIV_PER_STG;

      if (s > 0) begin : g_link
         assign src[s]       = data_ff[s-1];
         assign src_valid[s] = valid_ff[s-1];
      end

      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      always_comb begin
         logic [ttps_pkg::COORD_W:0] rr;
         logic [ttps_pkg::COORD_W:0] rc;
         nxt[s] = src[s];
         for (int j = 0; j < ttps_pkg::DIV_PER_STG; j++) begin
            rr = ttps_pkg::div_step(nxt[s].rem_row, bh_eff, 3'(TOP - j));
            rc = ttps_pkg::div_step(nxt[s].rem_col, bw_eff, 3'(TOP - j));
            nxt[s].rem_row = rr[ttps_pkg::COORD_W-1:0];
            nxt[s].rem_col = rc[ttps_pkg::COORD_W-1:0];
            // The last step yields the low quotient bits, which decide the parity.
            nxt[s].par     = rr[ttps_pkg::COORD_W] ^ rc[ttps_pkg::COORD_W];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && src_valid[s]) begin
            data_ff[s] <= nxt[s];
         end
      end
   end

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS-1] |-> ({1'b0, data_ff[NS-1].rem_row} < bh_eff
                          && {1'b0, data_ff[NS-1].rem_col} < bw_eff))
      else $error("divider remainder not below block size");

endmodule

/* rtl/core/ttps_shade.sv */
// Texel select, shade multiply and the result register.
// Two register stages: product, then the output pixel. Uses ttps_pkg.
module ttps_shade (
   input  logic               clock,
   input  logic               reset,
   input  ttps_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ttps_pkg::div_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         pixel_index,
   output logic               frame_done
);

   logic                           mul_valid_ff;
   logic [2*ttps_pkg::COLOR_W-1:0] prod_ff;
   logic [ttps_pkg::COLOR_W-1:0]   tex_ff;
   logic                           mul_fend_ff;
   logic [ttps_pkg::COLOR_W-1:0]   tex_in;
   logic                           mul_ready;
   logic                           out_valid_ff;
   logic [ttps_pkg::COLOR_W-1:0]   pix_ff;
   logic                           fend_ff;
   logic                           out_stage_ready;

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign mul_ready       = !mul_valid_ff || out_stage_ready;
   assign in_ready        = mul_ready;
   assign tex_in          = in_data.par ? cfg.odd_color : cfg.even_color;
   assign out_valid       = out_valid_ff;
   assign pixel_index     = pix_ff;
   assign frame_done      = fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (out_stage_ready) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         prod_ff     <= {{ttps_pkg::COLOR_W{1'b0}}, in_data.shade}
                      * {{ttps_pkg::COORD_W{1'b0}}, tex_in};
         tex_ff      <= tex_in;
         mul_fend_ff <= in_data.fend;
      end
      if (out_stage_ready && mul_valid_ff) begin
         pix_ff  <= cfg.shade_en ? prod_ff[2*ttps_pkg::COLOR_W-1:ttps_pkg::COLOR_W] : tex_ff;
         fend_ff <= mul_fend_ff;
      end
   end

endmodule

/* rtl/core/tunnel_texture_pixel_shader.sv */
// Top level of the tunnel texture pixel shader: configuration registers and the pipeline.
// Instantiates ttps_addr, ttps_div and ttps_shade; uses ttps_pkg.
//
//   port group   direction   contents
//   req_*        in          one tunnel map entry per request, tlast marks frame end
//   rsp_*        out         one palette index per request, tlast copies frame end
//   csr_*        in          register writes, index and data, no read-back
//
// A request enters every cycle while rsp does not stall; it passes seven register stages:
// one address stage, four divider stages (two quotient bits each), the shade multiply
// and the output register. Frame positions advance at the accept edge of a frame-end
// request, so the next request already sees them. Reset is synchronous and clears all
// valid bits and the positions and loads the defaults into the configuration registers;
// a stall on rsp holds every stage in place and backs up to req_tready without dropping
// a request.
module tunnel_texture_pixel_shader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // angle_coord[7:0], depth_coord[15:8], shade_level[23:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel_index[7:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ttps_pkg::cfg_type cfg_ff;
   ttps_pkg::cfg_type cfg_in;
   logic              addr_valid;
   logic              addr_ready;
   ttps_pkg::pix_type addr_data;
   logic              div_valid;
   logic              div_ready;
   ttps_pkg::div_type div_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ttps_pkg::CSR_SHADE_EN:  cfg_in.shade_en   = csr_wdata[0];
            ttps_pkg::CSR_BLOCK_W:   cfg_in.block_w    = csr_wdata[8:0];
            ttps_pkg::CSR_BLOCK_H:   cfg_in.block_h    = csr_wdata[8:0];
            ttps_pkg::CSR_EVEN:      cfg_in.even_color = csr_wdata[7:0];
            ttps_pkg::CSR_ODD:       cfg_in.odd_color  = csr_wdata[7:0];
            ttps_pkg::CSR_MOVE_STEP: cfg_in.move_step  = csr_wdata;
            ttps_pkg::CSR_TURN_STEP: cfg_in.turn_step  = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shade_en   <= 1'b1;
         cfg_ff.block_w    <= 9'd32;
         cfg_ff.block_h    <= 9'd32;
         cfg_ff.even_color <= 8'd20;
         cfg_ff.odd_color  <= 8'd128;
         cfg_ff.move_step  <= 16'sd154;
         cfg_ff.turn_step  <= 16'sd77;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttps_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .angle_coord (req_tdata[7:0]),
      .depth_coord (req_tdata[15:8]),
      .shade_level (req_tdata[23:16]),
      .frame_end   (req_tlast),
      .out_valid   (addr_valid),
      .out_ready   (addr_ready),
      .out_data    (addr_data)
   );

   ttps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (addr_valid),
      .in_ready  (addr_ready),
      .in_data   (addr_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   ttps_shade u_shade (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_data     (div_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .pixel_index (rsp_tdata),
      .frame_done  (rsp_tlast)
   );

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while the result register is empty");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_size_nonzero_ok: assert property (@(posedge clock) disable iff (reset)
      $past(csr_we) && $past(csr_index) == ttps_pkg::CSR_BLOCK_W
      |-> cfg_ff.block_w == $past(csr_wdata[8:0]))
      else $error("block width write lost");

endmodule

/* test/tunnel_texture_pixel_shader_test.sv */
// Self-checking testbench for tunnel_texture_pixel_shader: directed and random requests,
// with a local shading predictor, random stalls on both streams and register rewrites.
// Depends on ttps_pkg and the tunnel_texture_pixel_shader RTL only.
module tunnel_texture_pixel_shader_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int             SETTLE_CYCLES  = 16;
   localparam int             HOLD_CYCLES    = 200;
   localparam int             WATCHDOG_LIMIT = 1000;
   localparam int             PHASE_PIXELS   = 75;
   localparam logic [2:0]     CSR_SPARE      = 3'd7;
   localparam logic [ttps_pkg::STEP_W-1:0] STEP_MOST_NEG = 16'h8000;
   localparam logic [ttps_pkg::STEP_W-1:0] STEP_MOST_POS = 16'h7fff;

   typedef struct packed {
      logic [7:0] pixel_index;
      logic       frame_done;
   } shaded_pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // angle_coord[7:0], depth_coord[15:8], shade_level[23:16]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // pixel_index[7:0]
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // Predictor copy of the registers and the frame positions.
   ttps_pkg::cfg_type           shader_cfg;
   logic [ttps_pkg::POS_W-1:0]  move_pos;
   logic [ttps_pkg::POS_W-1:0]  turn_pos;

   shaded_pixel_type expected_pixels[$];
   int            mismatches   = 0;
   int            quiet_cycles = 0;
   int            rsp_gap      = 0;
   bit            idling       = 1'b1;
   bit            hold_request = 1'b0;

   tunnel_texture_pixel_shader uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ttps_pkg::POS_W-1:0] step_position(
         input logic [ttps_pkg::POS_W-1:0]        pos,
         input logic signed [ttps_pkg::STEP_W-1:0] step);
      int p;
      p = int'(pos) + int'(step);
      if (p > 65536) begin
         p = 0;
      end else if (p < 0) begin
         p = 65536;
      end
      return p[ttps_pkg::POS_W-1:0];
   endfunction

   // Palette index of one tunnel pixel; advances the positions after a frame's last pixel.
   function automatic shaded_pixel_type shade_pixel(input logic [7:0] angle,
                                                    input logic [7:0] depth,
                                                    input logic [7:0] shade,
                                                    input logic       fend);
      logic [8:0]       move_int;
      logic [8:0]       turn_int;
      logic [7:0]       row_base;
      logic [15:0]      addr;
      logic [8:0]       bw;
      logic [8:0]       bh;
      int               parity;
      logic [7:0]       texel;
      logic [15:0]      product;
      shaded_pixel_type res;
      move_int = move_pos[16:8];
      turn_int = turn_pos[16:8];
      row_base = depth + move_int[7:0];
      // A negative address borrows from the row; the 16-bit result wraps.
      addr     = {row_base, angle} - {7'd0, turn_int};
      bw       = (shader_cfg.block_w == '0) ? 9'd1 : shader_cfg.block_w;
      bh       = (shader_cfg.block_h == '0) ? 9'd1 : shader_cfg.block_h;
      parity   = (int'(addr[15:8]) / int'(bh) + int'(addr[7:0]) / int'(bw)) & 1;
      texel    = (parity != 0) ? shader_cfg.odd_color : shader_cfg.even_color;
      product  = {8'd0, shade} * {8'd0, texel};
      res.pixel_index = shader_cfg.shade_en ? product[15:8] : texel;
      res.frame_done  = fend;
      if (fend) begin
         move_pos = step_position(move_pos, shader_cfg.move_step);
         turn_pos = step_position(turn_pos, shader_cfg.turn_step);
      end
      return res;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         ttps_pkg::CSR_SHADE_EN:  shader_cfg.shade_en   = data[0];
         ttps_pkg::CSR_BLOCK_W:   shader_cfg.block_w    = data[8:0];
         ttps_pkg::CSR_BLOCK_H:   shader_cfg.block_h    = data[8:0];
         ttps_pkg::CSR_EVEN:      shader_cfg.even_color = data[7:0];
         ttps_pkg::CSR_ODD:       shader_cfg.odd_color  = data[7:0];
         ttps_pkg::CSR_MOVE_STEP: shader_cfg.move_step  = data;
         ttps_pkg::CSR_TURN_STEP: shader_cfg.turn_step  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] angle, input logic [7:0] depth,
                             input logic [7:0] shade, input logic fend);
      int gap;
      gap = idling ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {shade, depth, angle};
      req_tlast  <= fend;
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(shade_pixel(angle, depth, shade, fend));
   endtask

   // Stops offering requests and waits for every outstanding result.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd128, 1'b1);
      send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
   endtask

   // Drives both positions through the top value and back to zero.
   task automatic test_position_wrap();
      drain();
      write_csr(ttps_pkg::CSR_MOVE_STEP, STEP_MOST_NEG);
      write_csr(ttps_pkg::CSR_TURN_STEP, STEP_MOST_NEG);
      send_pixel(8'd0, 8'd0, 8'd200, 1'b1);
      // Integer position of 256: the row is unchanged and the address drops by 256.
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      drain();
      write_csr(ttps_pkg::CSR_MOVE_STEP, STEP_MOST_POS);
      write_csr(ttps_pkg::CSR_TURN_STEP, STEP_MOST_POS);
      send_pixel(8'd10, 8'd20, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
   endtask

   task automatic test_block_shapes();
      drain();
      write_csr(ttps_pkg::CSR_SHADE_EN, 16'hfffe);
      write_csr(ttps_pkg::CSR_BLOCK_W, {7'h7f, 9'd1});
      write_csr(ttps_pkg::CSR_BLOCK_H, {7'h7f, 9'd1});
      write_csr(ttps_pkg::CSR_EVEN, 16'h00ff);
      write_csr(ttps_pkg::CSR_ODD, 16'hff00);
      send_pixel(8'd0, 8'd0, 8'd17, 1'b0);
      send_pixel(8'd1, 8'd0, 8'd17, 1'b0);
      send_pixel(8'd1, 8'd1, 8'd17, 1'b0);
      drain();
      // A zero block size acts as a size of one.
      write_csr(ttps_pkg::CSR_BLOCK_W, 16'd0);
      write_csr(ttps_pkg::CSR_BLOCK_H, 16'd0);
      send_pixel(8'd3, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd3, 8'd3, 8'd0, 1'b0);
      drain();
      write_csr(ttps_pkg::CSR_SHADE_EN, 16'h0001);
      write_csr(ttps_pkg::CSR_BLOCK_W, 16'd256);
      write_csr(ttps_pkg::CSR_BLOCK_H, 16'd511);
      write_csr(ttps_pkg::CSR_EVEN, 16'h00fe);
      write_csr(ttps_pkg::CSR_ODD, 16'h00ff);
      send_pixel(8'd200, 8'd100, 8'd255, 1'b0);
      send_pixel(8'd55, 8'd250, 8'd254, 1'b0);
      drain();
      // Writes to an index past the last register leave everything unchanged.
      write_csr(CSR_SPARE, 16'hffff);
      send_pixel(8'd77, 8'd66, 8'd255, 1'b0);
   endtask

   function automatic logic [8:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd256;
         3:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [7:0] pick_color();
      return ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(0, 7))
         0:       return STEP_MOST_NEG;
         1:       return STEP_MOST_POS;
         2, 3:    return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic randomize_settings();
      write_csr(ttps_pkg::CSR_SHADE_EN, 16'($urandom));
      write_csr(ttps_pkg::CSR_BLOCK_W, {7'($urandom), pick_size()});
      write_csr(ttps_pkg::CSR_BLOCK_H, {7'($urandom), pick_size()});
      write_csr(ttps_pkg::CSR_EVEN, {8'($urandom), pick_color()});
      write_csr(ttps_pkg::CSR_ODD, {8'($urandom), pick_color()});
      write_csr(ttps_pkg::CSR_MOVE_STEP, pick_step());
      write_csr(ttps_pkg::CSR_TURN_STEP, pick_step());
      write_csr(CSR_SPARE, 16'($urandom));
   endtask

   // Random frames under changing settings; one phase runs without idling and one
   // starts with a long receiver hold-off so the pipeline backs up into the request side.
   task automatic test_random_frames();
      int phase;
      int sent;
      int frame_len;
      int k;
      for (phase = 0; phase < 6; phase++) begin
         drain();
         randomize_settings();
         idling = (phase != 2);
         if (phase == 3) begin
            hold_request = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            frame_len = $urandom_range(1, 24);
            for (k = 0; k < frame_len && sent < PHASE_PIXELS; k++) begin
               send_pixel(8'($urandom), 8'($urandom), 8'($urandom), k == frame_len - 1);
               sent++;
            end
         end
      end
      idling = 1'b1;
   endtask

   // Receiver: after each result it waits a random number of cycles (none while idling is off) before taking the next.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      shaded_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_gap = idling ? $urandom_range(0, 6) : 0;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: result with no request pending: pixel_index %0d frame_done %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pixel_index) begin
               mismatches++;
               $display("%0t: pixel_index expected %0d actual %0d",
                        $time, want.pixel_index, rsp_tdata);
            end
            if (rsp_tlast !== want.frame_done) begin
               mismatches++;
               $display("%0t: frame_done expected %0b actual %0b",
                        $time, want.frame_done, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      shader_cfg = '{shade_en: 1'b1, block_w: 9'd32, block_h: 9'd32, even_color: 8'd20,
                     odd_color: 8'd128, move_step: 16'sd154, turn_step: 16'sd77};
      move_pos   = '0;
      turn_pos   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_position_wrap();
      test_block_shapes();
      test_random_frames();
      drain();

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
